FILE: hdl/cppd_pkg.sv
// ----------------------------------------------------------------------------
// cppd_pkg
// Shared types, constants and helpers of the column post picture decoder.
// ----------------------------------------------------------------------------
package cppd_pkg;

  localparam int unsigned MaxWidth       = 512;
  localparam int unsigned MaxHeight      = 512;
  localparam int unsigned PaletteEntries = 256;

  localparam int unsigned DimW   = 10;
  localparam int unsigned SlotW  = $clog2(PaletteEntries);
  localparam int unsigned RgbW   = 24;
  localparam int unsigned ColW   = 9;
  localparam int unsigned RowW   = 9;
  localparam int unsigned AddrW  = 18;

  localparam logic [7:0] EndMark = 8'hFF;
  localparam logic [7:0] Opaque  = 8'd255;

  // command queue between parser and pixel writer
  localparam int unsigned CmdDepth  = 4;
  localparam int unsigned CmdPtrW   = $clog2(CmdDepth);
  localparam int unsigned CmdCountW = $clog2(CmdDepth + 1);

  // result queue at the output of the pixel writer
  localparam int unsigned OutDepth  = 4;
  localparam int unsigned OutPtrW   = $clog2(OutDepth);
  localparam int unsigned OutCountW = $clog2(OutDepth + 1);

  // configuration register indexes
  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef enum logic [1:0] {
    ACT_PALETTE = 2'd0,
    ACT_COLUMN  = 2'd1,
    ACT_BYTE    = 2'd2,
    ACT_RSVD    = 2'd3
  } action_e;

  typedef enum logic {
    CMD_PALETTE = 1'b0,
    CMD_PIXEL   = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] palette_slot;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
    logic [8:0] column_number;
    logic [7:0] stream_byte;
  } in_item_t;

  typedef struct packed {
    logic [17:0] pixel_address;
    logic [8:0]  pixel_column;
    logic [8:0]  pixel_row;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
  } res_t;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [SlotW-1:0] slot;
    logic [RgbW-1:0]  rgb;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
  } cmd_t;

  typedef struct packed {
    logic [OutCountW-1:0] level;
    logic                 s1_valid;
  } bk_stat_t;

  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v, logic [DimW-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

endpackage

FILE: hdl/cppd_front.sv
// ----------------------------------------------------------------------------
// cppd_front
// Column stream parser: tracks post phase, turns items into commands.
// ----------------------------------------------------------------------------
module cppd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  cppd_pkg::in_item_t item_i,
  input  logic [9:0]        width_i,
  input  logic [9:0]        height_i,
  output logic              cmd_valid_o,
  output cppd_pkg::cmd_t    cmd_o
);
  import cppd_pkg::*;

  typedef enum logic [5:0] {
    PH_TOP  = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_PAD  = 6'b000100,
    PH_DATA = 6'b001000,
    PH_TAIL = 6'b010000,
    PH_DONE = 6'b100000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [7:0]      top_q, top_d;
  logic [7:0]      remain_q, remain_d;
  logic [7:0]      step_q, step_d;
  logic [ColW-1:0] column_q, column_d;

  logic [RowW-1:0] row;
  logic [DimW-1:0] w_eff, h_eff;
  logic            in_bounds;

  assign row       = RowW'({1'b0, top_q} + {1'b0, step_q});
  assign w_eff     = clamp_dim(width_i, DimW'(MaxWidth));
  assign h_eff     = clamp_dim(height_i, DimW'(MaxHeight));
  assign in_bounds = ({1'b0, row} < h_eff) && ({1'b0, column_q} < w_eff);

  always_comb begin
    phase_d     = phase_q;
    top_d       = top_q;
    remain_d    = remain_q;
    step_d      = step_q;
    column_d    = column_q;
    cmd_valid_o = 1'b0;
    cmd_o.kind  = CMD_PIXEL;
    cmd_o.slot  = item_i.stream_byte;
    cmd_o.rgb   = {item_i.entry_red, item_i.entry_green, item_i.entry_blue};
    cmd_o.row   = row;
    cmd_o.col   = column_q;
    if (accept_i) begin
      unique case (action_e'(item_i.action))
        ACT_PALETTE: begin
          cmd_valid_o = 1'b1;
          cmd_o.kind  = CMD_PALETTE;
          cmd_o.slot  = item_i.palette_slot;
        end
        ACT_COLUMN: begin
          column_d = item_i.column_number;
          phase_d  = PH_TOP;
          top_d    = '0;
          remain_d = '0;
          step_d   = '0;
        end
        ACT_BYTE: begin
          unique case (phase_q)
            PH_TOP: begin
              if (item_i.stream_byte == EndMark) begin
                phase_d = PH_DONE;
              end else begin
                top_d   = item_i.stream_byte;
                phase_d = PH_LEN;
              end
            end
            PH_LEN: begin
              remain_d = item_i.stream_byte;
              step_d   = '0;
              phase_d  = PH_PAD;
            end
            PH_PAD: begin
              phase_d = (remain_q == '0) ? PH_TAIL : PH_DATA;
            end
            PH_DATA: begin
              cmd_valid_o = in_bounds;
              remain_d    = remain_q - 8'd1;
              if (remain_q == 8'd1) begin
                phase_d = PH_TAIL;
              end else begin
                step_d = step_q + 8'd1;
              end
            end
            PH_TAIL: begin
              phase_d = PH_TOP;
            end
            PH_DONE: begin
              phase_d = PH_DONE;
            end
            default: begin
              phase_d = PH_TOP;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TOP;
      top_q    <= '0;
      remain_q <= '0;
      step_q   <= '0;
      column_q <= '0;
    end else begin
      phase_q  <= phase_d;
      top_q    <= top_d;
      remain_q <= remain_d;
      step_q   <= step_d;
      column_q <= column_d;
    end
  end

endmodule

FILE: hdl/cppd_cmdq.sv
// ----------------------------------------------------------------------------
// cppd_cmdq
// Short command queue decoupling the parser from the pixel writer.
// ----------------------------------------------------------------------------
module cppd_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cppd_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output cppd_pkg::cmd_t cmd_o
);
  import cppd_pkg::*;

  cmd_t                 mem_q [CmdDepth];
  logic [CmdPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [CmdPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CmdCountW-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == CmdCountW'(CmdDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + CmdPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + CmdPtrW'(1);
    end
    count_d = count_q + CmdCountW'(do_push) - CmdCountW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: hdl/cppd_back.sv
// ----------------------------------------------------------------------------
// cppd_back
// Pixel writer: palette memory, address multiply and result queue.
// ----------------------------------------------------------------------------
module cppd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [9:0]         width_i,
  input  logic               cmd_empty_i,
  input  cppd_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output cppd_pkg::res_t     res_o,
  output cppd_pkg::bk_stat_t stat_o
);
  import cppd_pkg::*;

  logic [RgbW-1:0]      pal_mem [PaletteEntries];
  logic [RgbW-1:0]      rgb_q;
  logic                 s1_valid_q, s1_valid_d;
  logic [AddrW-1:0]     addr_q;
  logic [RowW-1:0]      row_q;
  logic [ColW-1:0]      col_q;

  res_t                 out_mem_q [OutDepth];
  logic [OutPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OutPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OutCountW-1:0] count_q, count_d;

  logic [DimW-1:0]      w_eff;
  logic [AddrW:0]       addr_full;
  logic                 room, pix_pop, pal_pop, out_pop;
  res_t                 s1_res;

  assign w_eff = clamp_dim(width_i, DimW'(MaxWidth));
  // row times stride plus column, wrapped to the address width
  assign addr_full = {{(AddrW+1-RowW){1'b0}}, cmd_i.row}
                   * {{(AddrW+1-DimW){1'b0}}, w_eff}
                   + {{(AddrW+1-ColW){1'b0}}, cmd_i.col};

  // keep a slot for the pixel already in flight
  assign room      = ({1'b0, count_q} + (OutCountW+1)'(s1_valid_q)) < (OutCountW+1)'(OutDepth);
  assign cmd_pop_o = !cmd_empty_i && room;
  assign pix_pop   = cmd_pop_o && (cmd_i.kind == CMD_PIXEL);
  assign pal_pop   = cmd_pop_o && (cmd_i.kind == CMD_PALETTE);
  assign s1_valid_d = pix_pop;

  assign empty_o = (count_q == '0);
  assign out_pop = pop_i && !empty_o;
  assign res_o   = out_mem_q[rd_ptr_q];

  assign stat_o.level    = count_q;
  assign stat_o.s1_valid = s1_valid_q;

  always_comb begin
    s1_res.pixel_address = addr_q;
    s1_res.pixel_column  = col_q;
    s1_res.pixel_row     = row_q;
    s1_res.out_red       = rgb_q[23:16];
    s1_res.out_green     = rgb_q[15:8];
    s1_res.out_blue      = rgb_q[7:0];
    s1_res.out_alpha     = Opaque;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (s1_valid_q) begin
      wr_ptr_d = (wr_ptr_q == OutPtrW'(OutDepth - 1)) ? '0 : wr_ptr_q + OutPtrW'(1);
    end
    if (out_pop) begin
      rd_ptr_d = (rd_ptr_q == OutPtrW'(OutDepth - 1)) ? '0 : rd_ptr_q + OutPtrW'(1);
    end
    count_d = count_q + OutCountW'(s1_valid_q) - OutCountW'(out_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      count_q    <= count_d;
    end
  end

  // palette memory, registered read
  always_ff @(posedge clk_i) begin
    if (pal_pop) begin
      pal_mem[cmd_i.slot] <= cmd_i.rgb;
    end
    if (pix_pop) begin
      rgb_q <= pal_mem[cmd_i.slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_pop) begin
      addr_q <= addr_full[AddrW-1:0];
      row_q  <= cmd_i.row;
      col_q  <= cmd_i.col;
    end
    if (s1_valid_q) begin
      out_mem_q[wr_ptr_q] <= s1_res;
    end
  end

endmodule

FILE: hdl/column_post_picture_decoder.sv
// ----------------------------------------------------------------------------
// column_post_picture_decoder
// Palettized column post picture decoder: palette load and pixel writes.
// ----------------------------------------------------------------------------
// path: a data byte passes the command queue, stage-one registers, result queue
// throughput: one item per cycle unless a queue is full, set by the single palette
// memory port and the one-command-per-cycle pop of the pixel writer
// reset: parser, queues and config registers cleared at once, no clearing
// pass; palette entries are undefined until written
// ----------------------------------------------------------------------------
module column_post_picture_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [9:0]         cfg_data_i,
  // input queue side
  input  logic               push,
  output logic               full,
  input  cppd_pkg::in_item_t item_i,
  // result queue side
  output logic               empty,
  input  logic               pop,
  output cppd_pkg::res_t     res_o
);
  import cppd_pkg::*;

  logic [DimW-1:0] width_q, height_q;

  logic     accept;
  logic     cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t     cmd_in, cmd_out;
  bk_stat_t bk_stat;

  // config registers; the user writes them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWidth:  width_q  <= cfg_data_i;
        CfgHeight: height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // an input transfer needs one free command slot, even if it yields nothing
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // front: parse stream bytes, drop out-of-range pixels
  cppd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item_i),
    .width_i     (width_q),
    .height_i    (height_q),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd_in)
  );

  // command queue: palette writes and pixels stay in stream order
  cppd_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .cmd_o   (cmd_out)
  );

  // back: palette lookup, address multiply, result queue
  cppd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (width_q),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res_o),
    .stat_o      (bk_stat)
  );

  // every waiting result is an opaque pixel
  a_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> res_o.out_alpha == Opaque)
    else $error("result with non-opaque alpha");

  // result queue never holds more than its depth
  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.level <= OutCountW'(OutDepth))
    else $error("result queue overflow");

  // taking the last result with nothing in flight leaves the queue empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && bk_stat.level == OutCountW'(1) && !bk_stat.s1_valid) |=> empty)
    else $error("result queue not empty after last transfer");

  // the writer never pops a command from an empty queue
  a_cmd_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");

endmodule
